// ===== sv/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, axis and bound indexes, and stage payload types for the
// ray / box slab test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int NUM_AXES    = 3;

  localparam int AX_X    = 0;
  localparam int AX_Y    = 1;
  localparam int AX_Z    = 2;
  localparam int BND_MIN = 0;
  localparam int BND_MAX = 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic        [COORD_WIDTH-1:0] mag_t;
  typedef logic        [PROD_W-1:0]      prod_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } bsign_t;

  typedef struct packed {
    bsign_t sg;
    mag_t   mag;
  } bound_t;

  typedef struct packed {
    bound_t [1:0] bnd;
    mag_t         den;
    logic         unb;
  } axis_t;

  typedef struct packed {
    axis_t [NUM_AXES-1:0] ax;
    logic                 org_in;
    logic                 miss;
  } slab_t;

  typedef struct packed {
    prod_t  [NUM_AXES-1:0][1:0][1:0] p;
    bsign_t [NUM_AXES-1:0][1:0]      sg;
    logic   [NUM_AXES-1:0]           unb;
    logic                            org_in;
    logic                            miss;
  } mul_t;

  // j-th axis other than a
  function automatic int other_axis(int a, int j);
    return (a + 1 + j) % NUM_AXES;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rbs_front.sv =====
// ----------------------------------------------------------------------------
// rbs_front
// Two stages: bound differences, then per-axis slab bounds as sign and
// magnitude over the direction magnitude, plus inside and miss flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] origin,
  input  wire rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] dir,
  input  wire rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] box_min,
  input  wire rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] box_max,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output rbs_pkg::slab_t                            out_slab
);

  logic en1;
  logic en2;
  logic v1_r;
  logic v2_r;

  rbs_pkg::diff_t  [rbs_pkg::NUM_AXES-1:0] dlo_nxt;
  rbs_pkg::diff_t  [rbs_pkg::NUM_AXES-1:0] dhi_nxt;
  rbs_pkg::diff_t  [rbs_pkg::NUM_AXES-1:0] dlo_r;
  rbs_pkg::diff_t  [rbs_pkg::NUM_AXES-1:0] dhi_r;
  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] dir_r;
  rbs_pkg::slab_t                          slab_nxt;
  rbs_pkg::slab_t                          slab_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      dlo_nxt[a] = rbs_pkg::diff_t'(box_min[a]) - rbs_pkg::diff_t'(origin[a]);
      dhi_nxt[a] = rbs_pkg::diff_t'(box_max[a]) - rbs_pkg::diff_t'(origin[a]);
    end
  end

  always_comb begin
    logic           lo_neg;
    logic           lo_zero;
    logic           hi_neg;
    logic           hi_zero;
    logic           dneg;
    logic           unb;
    rbs_pkg::diff_t lo_abs;
    rbs_pkg::diff_t hi_abs;
    rbs_pkg::mag_t  lo_mag;
    rbs_pkg::mag_t  hi_mag;
    slab_nxt        = '0;
    slab_nxt.org_in = 1'b1;
    slab_nxt.miss   = 1'b0;
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      lo_neg  = dlo_r[a][rbs_pkg::DIFF_W-1];
      lo_zero = (dlo_r[a] == '0);
      hi_neg  = dhi_r[a][rbs_pkg::DIFF_W-1];
      hi_zero = (dhi_r[a] == '0);
      lo_abs  = lo_neg ? -dlo_r[a] : dlo_r[a];
      hi_abs  = hi_neg ? -dhi_r[a] : dhi_r[a];
      lo_mag  = lo_abs[rbs_pkg::COORD_WIDTH-1:0];
      hi_mag  = hi_abs[rbs_pkg::COORD_WIDTH-1:0];
      dneg    = dir_r[a][rbs_pkg::COORD_WIDTH-1];
      unb     = (dir_r[a] == '0);
      slab_nxt.org_in = slab_nxt.org_in && (lo_neg || lo_zero) && !hi_neg;
      slab_nxt.miss   = slab_nxt.miss || (unb && ((!lo_neg && !lo_zero) || hi_neg));
      slab_nxt.ax[a].unb = unb;
      slab_nxt.ax[a].den = dneg ? rbs_pkg::mag_t'(-dir_r[a]) : rbs_pkg::mag_t'(dir_r[a]);
      if (!dneg) begin
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MIN].sg.neg  = lo_neg;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MIN].sg.zero = lo_zero;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MIN].mag     = lo_mag;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MAX].sg.neg  = hi_neg;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MAX].sg.zero = hi_zero;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MAX].mag     = hi_mag;
      end else begin
        // negative direction swaps and negates the bounds
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MIN].sg.neg  = !hi_neg && !hi_zero;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MIN].sg.zero = hi_zero;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MIN].mag     = hi_mag;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MAX].sg.neg  = !lo_neg && !lo_zero;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MAX].sg.zero = lo_zero;
        slab_nxt.ax[a].bnd[rbs_pkg::BND_MAX].mag     = lo_mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
    if (en1 && in_valid) begin
      dlo_r <= dlo_nxt;
      dhi_r <= dhi_nxt;
      dir_r <= dir;
    end
    if (en2 && v1_r) begin
      slab_r <= slab_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_slab  = slab_r;

endmodule

`default_nettype wire

// ===== sv/rbs_mul.sv =====
// ----------------------------------------------------------------------------
// rbs_mul
// Cross products: every bound magnitude of an axis times the direction
// magnitude of each other axis, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_mul (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rbs_pkg::slab_t in_slab,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rbs_pkg::mul_t       out_mul
);

  logic          v_r;
  logic          en;
  rbs_pkg::mul_t mul_nxt;
  rbs_pkg::mul_t mul_r;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    mul_nxt        = '0;
    mul_nxt.org_in = in_slab.org_in;
    mul_nxt.miss   = in_slab.miss;
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      mul_nxt.unb[a] = in_slab.ax[a].unb;
      for (int b = 0; b < 2; b++) begin
        mul_nxt.sg[a][b] = in_slab.ax[a].bnd[b].sg;
        for (int j = 0; j < 2; j++) begin
          mul_nxt.p[a][b][j] = rbs_pkg::prod_t'(in_slab.ax[a].bnd[b].mag) *
                               rbs_pkg::prod_t'(in_slab.ax[rbs_pkg::other_axis(a, j)].den);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
    if (en && in_valid) begin
      mul_r <= mul_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_mul   = mul_r;

endmodule

`default_nettype wire

// ===== sv/rbs_decide.sv =====
// ----------------------------------------------------------------------------
// rbs_decide
// Two stages: the eight slab parameter comparisons, then interval narrowing
// and the final hit decision into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_decide (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rbs_pkg::mul_t in_mul,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_hit,
  output logic               out_origin_inside
);

  logic       en4;
  logic       en5;
  logic       v4_r;
  logic       v5_r;
  logic [7:0] c_nxt;
  logic [7:0] c_r;
  logic       inside_r;
  logic       miss_r;
  logic       zsep;
  logic       hit_nxt;
  logic       hit_r;
  logic       oi_r;
  logic       ux;
  logic       uy;
  logic       uz;

  function automatic logic pidx(int a, int k);
    return (k == rbs_pkg::other_axis(a, 0)) ? 1'b0 : 1'b1;
  endfunction

  // finite a > b, fractions num/den with den > 0
  function automatic logic fin(rbs_pkg::mul_t m, int aa, int ab, int ba, int bb);
    rbs_pkg::bsign_t sa;
    rbs_pkg::bsign_t sb;
    rbs_pkg::prod_t  pa;
    rbs_pkg::prod_t  pb;
    logic [1:0]      ra;
    logic [1:0]      rb;
    logic            res;
    sa = m.sg[aa][ab];
    sb = m.sg[ba][bb];
    pa = m.p[aa][ab][pidx(aa, ba)];
    pb = m.p[ba][bb][pidx(ba, aa)];
    ra = sa.neg ? 2'd0 : (sa.zero ? 2'd1 : 2'd2);
    rb = sb.neg ? 2'd0 : (sb.zero ? 2'd1 : 2'd2);
    if (ra != rb) begin
      res = (ra > rb);
    end else if (sa.zero) begin
      res = 1'b0;
    end else if (sa.neg) begin
      res = (pa < pb);
    end else begin
      res = (pa > pb);
    end
    return res;
  endfunction

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign in_ready = en4;

  assign ux = in_mul.unb[rbs_pkg::AX_X];
  assign uy = in_mul.unb[rbs_pkg::AX_Y];
  assign uz = in_mul.unb[rbs_pkg::AX_Z];

  always_comb begin
    c_nxt[0] = !(ux || uy) &&
               fin(in_mul, rbs_pkg::AX_X, rbs_pkg::BND_MIN, rbs_pkg::AX_Y, rbs_pkg::BND_MAX);
    c_nxt[1] = !(ux || uy) &&
               fin(in_mul, rbs_pkg::AX_Y, rbs_pkg::BND_MIN, rbs_pkg::AX_X, rbs_pkg::BND_MAX);
    c_nxt[2] = (ux || uy) ? (ux && !uy) :
               fin(in_mul, rbs_pkg::AX_Y, rbs_pkg::BND_MIN, rbs_pkg::AX_X, rbs_pkg::BND_MIN);
    c_nxt[3] = (ux || uy) ? (ux && !uy) :
               fin(in_mul, rbs_pkg::AX_X, rbs_pkg::BND_MAX, rbs_pkg::AX_Y, rbs_pkg::BND_MAX);
    c_nxt[4] = !(ux || uz) &&
               fin(in_mul, rbs_pkg::AX_X, rbs_pkg::BND_MIN, rbs_pkg::AX_Z, rbs_pkg::BND_MAX);
    c_nxt[5] = !(uy || uz) &&
               fin(in_mul, rbs_pkg::AX_Y, rbs_pkg::BND_MIN, rbs_pkg::AX_Z, rbs_pkg::BND_MAX);
    c_nxt[6] = !(ux || uz) &&
               fin(in_mul, rbs_pkg::AX_Z, rbs_pkg::BND_MIN, rbs_pkg::AX_X, rbs_pkg::BND_MAX);
    c_nxt[7] = !(uy || uz) &&
               fin(in_mul, rbs_pkg::AX_Z, rbs_pkg::BND_MIN, rbs_pkg::AX_Y, rbs_pkg::BND_MAX);
  end

  // narrowed interval picks y bounds where they are tighter
  assign zsep    = (c_r[2] ? c_r[5] : c_r[4]) || (c_r[3] ? c_r[7] : c_r[6]);
  assign hit_nxt = inside_r || (!miss_r && !c_r[0] && !c_r[1] && !zsep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
    end
    if (en4 && in_valid) begin
      c_r      <= c_nxt;
      inside_r <= in_mul.org_in;
      miss_r   <= in_mul.miss;
    end
    if (en5 && v4_r) begin
      hit_r <= hit_nxt;
      oi_r  <= inside_r;
    end
  end

  assign out_valid         = v5_r;
  assign out_hit           = hit_r;
  assign out_origin_inside = oi_r;

endmodule

`default_nettype wire

// ===== sv/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Stages: bound differences, slab bounds, cross products, comparisons, hit decision.
// Throughput: one ray / box pair per cycle unless out_ready stalls the
// output; the 32x32 cross products sit in a stage of their own.
// Each stage holds its item until the next one frees, so bubbles close up.
// Reset: synchronous active low, clears stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rbs_pkg::coord_t in_origin_x,
  input  wire rbs_pkg::coord_t in_origin_y,
  input  wire rbs_pkg::coord_t in_origin_z,
  input  wire rbs_pkg::coord_t in_dir_x,
  input  wire rbs_pkg::coord_t in_dir_y,
  input  wire rbs_pkg::coord_t in_dir_z,
  input  wire rbs_pkg::coord_t in_box_min_x,
  input  wire rbs_pkg::coord_t in_box_min_y,
  input  wire rbs_pkg::coord_t in_box_min_z,
  input  wire rbs_pkg::coord_t in_box_max_x,
  input  wire rbs_pkg::coord_t in_box_max_y,
  input  wire rbs_pkg::coord_t in_box_max_z,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_hit,
  output logic                 out_origin_inside
);

  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] origin;
  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] dir;
  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] box_min;
  rbs_pkg::coord_t [rbs_pkg::NUM_AXES-1:0] box_max;

  logic           front_valid;
  logic           front_ready;
  rbs_pkg::slab_t slab;
  logic           mul_valid;
  logic           mul_ready;
  rbs_pkg::mul_t  prods;

  assign origin  = {in_origin_z, in_origin_y, in_origin_x};
  assign dir     = {in_dir_z, in_dir_y, in_dir_x};
  assign box_min = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign box_max = {in_box_max_z, in_box_max_y, in_box_max_x};

  rbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .origin    (origin),
    .dir       (dir),
    .box_min   (box_min),
    .box_max   (box_max),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_slab  (slab)
  );

  rbs_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_slab   (slab),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_mul   (prods)
  );

  rbs_decide u_decide (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (mul_valid),
    .in_ready          (mul_ready),
    .in_mul            (prods),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_origin_inside (out_origin_inside)
  );

  // an inside result is always a hit
  a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit || !out_origin_inside))
    else $error("origin_inside without hit");

  // input backs up only when every stage is full and the output stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && mul_valid && front_valid))
    else $error("input stalled with room in pipeline");

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !mul_valid && !front_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
